// File: design/fpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point signed divider package
// Shared widths, status codes and the per-word flag bundle.
// ----------------------------------------------------------------------------
package fpsd_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Flags that ride along with each word through the division stages.
  typedef struct packed {
    logic neg;
    logic div_zero;
  } flags_t;

endpackage
`default_nettype wire

// File: design/fpsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point signed divider channels
// Operand and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpsd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpsd_pkg::WORD_W-1:0] dividend;
  logic signed [fpsd_pkg::WORD_W-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface fpsd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpsd_pkg::WORD_W-1:0] quotient;
  fpsd_pkg::status_e                   status;

  modport source (output valid, output quotient, output status, input ready);
  modport sink   (input valid, input quotient, input status, output ready);
endinterface
`default_nettype wire

// File: design/fixed_point_signed_divider.sv
// Each word passes the preparation register, the restoring stages and the output register.
// Throughput: one word per cycle while dout_o is not stalled; each of the 32 + FRAC_BITS
//   restoring stages is its own registered stage, so a new word can enter on every clock.
// Reset: rst_ni clears all valid bits asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed fixed-point divider
// Divides two signed 32-bit fixed-point words with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module fixed_point_signed_divider #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpsd_in_if.sink     din_i,
  fpsd_out_if.source  dout_o
);

  // The magnitude numerator is |dividend| shifted left by FRAC_BITS, one
  // quotient bit per numerator bit.
  localparam int unsigned NUM_W = fpsd_pkg::WORD_W + FRAC_BITS;

  // Index 0 is the preparation stage output; index k+1 is the output of
  // division step k. Every stage has its own valid bit and a ready that only
  // depends on its own occupancy and the stage after it, so bubbles are
  // squeezed out and a waiting result does not block new operands while
  // any stage is still empty.
  logic                        vld_s   [0:NUM_W];
  logic                        rdy_s   [0:NUM_W];
  logic [fpsd_pkg::WORD_W-1:0] rem_s   [0:NUM_W];
  logic [NUM_W-1:0]            num_s   [0:NUM_W];
  logic [fpsd_pkg::WORD_W-1:0] den_s   [0:NUM_W];
  fpsd_pkg::flags_t            flg_s   [0:NUM_W];

  // Operand magnitudes, result sign and divide-by-zero detection.
  fpsd_prep #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .din_i   (din_i),
    .valid_o (vld_s[0]),
    .ready_i (rdy_s[0]),
    .num_o   (num_s[0]),
    .den_o   (den_s[0]),
    .flags_o (flg_s[0])
  );

  // The partial remainder starts at zero for every word.
  assign rem_s[0] = '0;

  // One restoring step per stage. After the last step the numerator register
  // holds the full magnitude quotient.
  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    fpsd_step #(
      .NUM_W (NUM_W)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_s[k]),
      .ready_o (rdy_s[k]),
      .rem_i   (rem_s[k]),
      .num_i   (num_s[k]),
      .den_i   (den_s[k]),
      .flags_i (flg_s[k]),
      .valid_o (vld_s[k+1]),
      .ready_i (rdy_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .num_o   (num_s[k+1]),
      .den_o   (den_s[k+1]),
      .flags_o (flg_s[k+1])
    );
  end

  // Sign, saturation and the output register. The final remainder and the
  // divisor are not needed here.
  fpsd_post #(
    .NUM_W (NUM_W)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_s[NUM_W]),
    .ready_o (rdy_s[NUM_W]),
    .quo_i   (num_s[NUM_W]),
    .flags_i (flg_s[NUM_W]),
    .dout_o  (dout_o)
  );

  // A divide-by-zero result always carries a zero quotient.
  a_div_zero_quot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dout_o.valid && (dout_o.status == fpsd_pkg::ST_DIV_ZERO)) |-> (dout_o.quotient == '0))
    else $error("divide-by-zero result with nonzero quotient");

  // A saturated result is one of the two extreme values.
  a_ovf_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dout_o.valid && (dout_o.status == fpsd_pkg::ST_OVERFLOW)) |->
    ((dout_o.quotient == 32'sh7fffffff) || (dout_o.quotient == 32'sh80000000)))
    else $error("overflow result is not saturated");

  // An accepted operand word lands in the preparation stage.
  a_prep_capture : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (din_i.valid && din_i.ready) |=> vld_s[0])
    else $error("accepted operand word lost at the preparation stage");

  // A full last stage that the output register refuses holds its word.
  a_last_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_s[NUM_W] && !rdy_s[NUM_W]) |=> (vld_s[NUM_W] && $stable(num_s[NUM_W])))
    else $error("last division stage dropped a stalled word");

endmodule
`default_nettype wire

// File: design/fpsd_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Operand preparation stage
// Takes operand magnitudes, the result sign and the zero-divisor flag.
// ----------------------------------------------------------------------------
module fpsd_prep #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned NUM_W     = 48
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  fpsd_in_if.sink                          din_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [NUM_W-1:0]                 num_o,
  output logic [fpsd_pkg::WORD_W-1:0]      den_o,
  output fpsd_pkg::flags_t                 flags_o
);

  logic                         valid_q, valid_d;
  logic [NUM_W-1:0]             num_q, num_d;
  logic [fpsd_pkg::WORD_W-1:0]  den_q, den_d;
  fpsd_pkg::flags_t             flags_q, flags_d;
  logic [fpsd_pkg::WORD_W-1:0]  mag_a, mag_b;
  logic                         load;

  assign din_i.ready = !valid_q || ready_i;
  assign load        = din_i.valid && din_i.ready;

  always_comb begin
    // The most negative value negates to itself, which is its magnitude unsigned.
    mag_a = din_i.dividend[fpsd_pkg::WORD_W-1] ? (~din_i.dividend + 1'b1) : din_i.dividend;
    mag_b = din_i.divisor[fpsd_pkg::WORD_W-1]  ? (~din_i.divisor + 1'b1)  : din_i.divisor;
    num_d = NUM_W'(mag_a) << FRAC_BITS;
    den_d = mag_b;
    flags_d.neg      = din_i.dividend[fpsd_pkg::WORD_W-1] ^ din_i.divisor[fpsd_pkg::WORD_W-1];
    flags_d.div_zero = (din_i.divisor == '0);
    valid_d = din_i.ready ? din_i.valid : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      num_q   <= num_d;
      den_q   <= den_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

// File: design/fpsd_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring division step
// Produces one quotient bit per stage and registers the partial state.
// ----------------------------------------------------------------------------
module fpsd_step #(
  parameter int unsigned NUM_W = 48
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [fpsd_pkg::WORD_W-1:0] rem_i,
  input  wire logic [NUM_W-1:0]            num_i,
  input  wire logic [fpsd_pkg::WORD_W-1:0] den_i,
  input  wire fpsd_pkg::flags_t            flags_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [fpsd_pkg::WORD_W-1:0]      rem_o,
  output logic [NUM_W-1:0]                 num_o,
  output logic [fpsd_pkg::WORD_W-1:0]      den_o,
  output fpsd_pkg::flags_t                 flags_o
);

  logic                         valid_q, valid_d;
  logic [fpsd_pkg::WORD_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]             num_q, num_d;
  logic [fpsd_pkg::WORD_W-1:0]  den_q;
  fpsd_pkg::flags_t             flags_q;
  logic [fpsd_pkg::WORD_W:0]    trial;
  logic [fpsd_pkg::WORD_W:0]    diff;
  logic                         fits;
  logic                         load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // The numerator shifts out from the top while quotient bits shift in below.
  always_comb begin
    trial   = {rem_i, num_i[NUM_W-1]};
    diff    = trial - {1'b0, den_i};
    fits    = !diff[fpsd_pkg::WORD_W];
    rem_d   = fits ? diff[fpsd_pkg::WORD_W-1:0] : trial[fpsd_pkg::WORD_W-1:0];
    num_d   = {num_i[NUM_W-2:0], fits};
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q   <= rem_d;
      num_q   <= num_d;
      den_q   <= den_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

// File: design/fpsd_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result stage
// Applies the sign, saturates on overflow, zeroes divide-by-zero results and holds the result word.
// ----------------------------------------------------------------------------
module fpsd_post #(
  parameter int unsigned NUM_W = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [NUM_W-1:0] quo_i,
  input  wire fpsd_pkg::flags_t flags_i,
  fpsd_out_if.source            dout_o
);

  localparam int unsigned W = fpsd_pkg::WORD_W;

  logic              valid_q, valid_d;
  logic [W-1:0]      quot_q, quot_d;
  fpsd_pkg::status_e status_q, status_d;
  logic              hi_set;
  logic              pos_ovf;
  logic              neg_ovf;
  logic              load;

  assign ready_o = !valid_q || dout_o.ready;
  assign load    = valid_i && ready_o;

  always_comb begin
    hi_set  = |quo_i[NUM_W-1:W];
    pos_ovf = hi_set || quo_i[W-1];
    neg_ovf = hi_set || (quo_i[W-1] && (|quo_i[W-2:0]));
    if (flags_i.div_zero) begin
      quot_d   = '0;
      status_d = fpsd_pkg::ST_DIV_ZERO;
    end else if (flags_i.neg) begin
      if (neg_ovf) begin
        quot_d   = {1'b1, {(W-1){1'b0}}};
        status_d = fpsd_pkg::ST_OVERFLOW;
      end else begin
        quot_d   = ~quo_i[W-1:0] + 1'b1;
        status_d = fpsd_pkg::ST_OK;
      end
    end else begin
      if (pos_ovf) begin
        quot_d   = {1'b0, {(W-1){1'b1}}};
        status_d = fpsd_pkg::ST_OVERFLOW;
      end else begin
        quot_d   = quo_i[W-1:0];
        status_d = fpsd_pkg::ST_OK;
      end
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quot_q   <= quot_d;
      status_q <= status_d;
    end
  end

  assign dout_o.valid    = valid_q;
  assign dout_o.quotient = quot_q;
  assign dout_o.status   = status_q;

endmodule
`default_nettype wire
